// ===== rtl/core/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants of the serial frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

    // Frame characters.
    localparam logic [7:0] CH_START     = 8'h23;  // '#'
    localparam logic [7:0] CH_ADDR_BASE = 8'h61;  // 'a'
    localparam logic [7:0] CH_OFFSET    = 8'h3D;  // '='
    localparam logic [7:0] CH_CR        = 8'h0D;  // carriage return

    // Character positions within one job. The header, group and close
    // sections follow one another and absent sections are skipped.
    localparam int POS_W = 4;
    typedef logic [POS_W-1:0] pos_t;
    localparam pos_t POS_HDR_START = 4'd0;
    localparam pos_t POS_HDR_ADDR  = 4'd1;
    localparam pos_t POS_HDR_CMD   = 4'd2;
    localparam pos_t POS_GRP_0     = 4'd3;
    localparam pos_t POS_GRP_1     = 4'd4;
    localparam pos_t POS_GRP_2     = 4'd5;
    localparam pos_t POS_GRP_3     = 4'd6;
    localparam pos_t POS_SUM_HI    = 4'd7;
    localparam pos_t POS_SUM_LO    = 4'd8;
    localparam pos_t POS_CR        = 4'd9;

    // Number of entries in the job queue.
    localparam int QUEUE_DEPTH = 2;

    // One classified request: which sections to emit and their data.
    typedef struct packed {
        logic       hdr;
        logic [7:0] cmd;
        logic [5:0] addr;
        logic       grp;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic       close;
    } job_t;

endpackage

// ===== rtl/core/sfe_in_if.sv =====
// ----------------------------------------------------------------------------
// sfe_in_if
// Input channel of the serial frame encoder: one payload byte request.
// ----------------------------------------------------------------------------
interface sfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd;
    logic [5:0] addr;
    logic [7:0] data_byte;
    logic       has_data;
    logic       first_byte;
    logic       last_byte;

    modport source (
        output valid, cmd, addr, data_byte, has_data, first_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, addr, data_byte, has_data, first_byte, last_byte,
        output ready
    );
endinterface

// ===== rtl/core/sfe_out_if.sv =====
// ----------------------------------------------------------------------------
// sfe_out_if
// Output channel of the serial frame encoder: one frame character.
// ----------------------------------------------------------------------------
interface sfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       frame_end;
    logic       run_last;

    modport source (
        output valid, out_char, frame_end, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_char, frame_end, run_last,
        output ready
    );
endinterface

// ===== rtl/core/sfe_front.sv =====
// ----------------------------------------------------------------------------
// sfe_front
// Accepts input requests, gathers payload bytes into groups of three and
// hands a job describing the characters to emit to the job queue.
// ----------------------------------------------------------------------------
module sfe_front (
    input  logic          clk,
    input  logic          rst_n,
    sfe_in_if.sink        in_ch,
    output logic          push,
    output sfe_pkg::job_t push_job,
    input  logic          queue_full
);

    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        accept;

    // A request is taken whenever the queue has room.
    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && !queue_full;

    // Classify the request and work out the group state after it.
    always_comb
    begin
        logic [15:0] held_v;
        logic [1:0]  fill_v;

        held_v = in_ch.first_byte ? 16'h0000 : held_reg;
        fill_v = in_ch.first_byte ? 2'd0 : fill_reg;

        push_job        = '0;
        push_job.hdr    = in_ch.first_byte;
        push_job.cmd    = in_ch.cmd;
        push_job.addr   = in_ch.addr;
        push_job.close  = in_ch.last_byte;

        // Gather the payload byte; the third byte completes a group.
        if (in_ch.has_data)
        begin
            unique case (fill_v)
                2'd0:
                begin
                    held_v = {in_ch.data_byte, 8'h00};
                    fill_v = 2'd1;
                end
                2'd1:
                begin
                    held_v = {held_v[15:8], in_ch.data_byte};
                    fill_v = 2'd2;
                end
                default:
                begin
                    push_job.grp    = 1'b1;
                    push_job.byte_a = held_v[15:8];
                    push_job.byte_b = held_v[7:0];
                    push_job.byte_c = in_ch.data_byte;
                    held_v          = 16'h0000;
                    fill_v          = 2'd0;
                end
            endcase
        end

        // At the end of the frame a partial group is padded with zeros.
        if (in_ch.last_byte)
        begin
            if (fill_v != 2'd0)
            begin
                push_job.grp    = 1'b1;
                push_job.byte_a = held_v[15:8];
                push_job.byte_b = (fill_v == 2'd2) ? held_v[7:0] : 8'h00;
                push_job.byte_c = 8'h00;
            end
            held_v = 16'h0000;
            fill_v = 2'd0;
        end

        held_next = held_v;
        fill_next = fill_v;
    end

    // Requests that cause no character are absorbed without a job.
    assign push = accept && (push_job.hdr || push_job.grp || push_job.close);

    // Group state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 16'h0000;
            fill_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== rtl/core/sfe_job_queue.sv =====
// ----------------------------------------------------------------------------
// sfe_job_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module sfe_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfe_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sfe_pkg::job_t head_job
);

    localparam int PTR_W = $clog2(sfe_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sfe_pkg::QUEUE_DEPTH + 1);

    sfe_pkg::job_t         entry_reg [sfe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign full       = (count_reg == CNT_W'(sfe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(sfe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(sfe_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/sfe_back.sv =====
// ----------------------------------------------------------------------------
// sfe_back
// Steps through the job at the head of the queue one character per cycle
// while not stalled, keeps the running checksum, drives the output register.
// ----------------------------------------------------------------------------
module sfe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sfe_pkg::job_t head_job,
    output logic          pop,
    sfe_out_if.source     out_ch
);

    logic              busy_reg;
    logic              busy_next;
    sfe_pkg::pos_t     pos_reg;
    sfe_pkg::pos_t     pos_next;
    logic [11:0]       sum_reg;
    logic [11:0]       sum_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        char_reg;
    logic [7:0]        char_next;
    logic              end_reg;
    logic              end_next;
    logic              last_reg;
    logic              last_next;
    logic              load;
    sfe_pkg::pos_t     cur_pos;
    logic              job_done;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_char  = char_reg;
    assign out_ch.frame_end = end_reg;
    assign out_ch.run_last  = last_reg;

    // A new character enters the output register when it is free or taken.
    assign load = head_valid && (!out_valid_reg || out_ch.ready);
    assign pop  = load && job_done;

    // Character selection, checksum and position sequencing.
    always_comb
    begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;

        a = head_job.byte_a;
        b = head_job.byte_b;
        c = head_job.byte_c;

        // A fresh job starts at its first present section.
        if (busy_reg)
        begin
            cur_pos = pos_reg;
        end
        else if (head_job.hdr)
        begin
            cur_pos = sfe_pkg::POS_HDR_START;
        end
        else if (head_job.grp)
        begin
            cur_pos = sfe_pkg::POS_GRP_0;
        end
        else
        begin
            cur_pos = sfe_pkg::POS_SUM_HI;
        end

        end_next = 1'b0;
        unique case (cur_pos)
            sfe_pkg::POS_HDR_START: char_next = sfe_pkg::CH_START;
            sfe_pkg::POS_HDR_ADDR:
                char_next = sfe_pkg::CH_ADDR_BASE + {2'b00, head_job.addr};
            sfe_pkg::POS_HDR_CMD:   char_next = head_job.cmd;
            sfe_pkg::POS_GRP_0:
                char_next = sfe_pkg::CH_OFFSET + {2'b00, a[7:2]};
            sfe_pkg::POS_GRP_1:
                char_next = sfe_pkg::CH_OFFSET + {2'b00, a[1:0], b[7:4]};
            sfe_pkg::POS_GRP_2:
                char_next = sfe_pkg::CH_OFFSET + {2'b00, b[3:0], c[7:6]};
            sfe_pkg::POS_GRP_3:
                char_next = sfe_pkg::CH_OFFSET + {2'b00, c[5:0]};
            sfe_pkg::POS_SUM_HI:
                char_next = sfe_pkg::CH_OFFSET + {2'b00, sum_reg[11:6]};
            sfe_pkg::POS_SUM_LO:
                char_next = sfe_pkg::CH_OFFSET + {2'b00, sum_reg[5:0]};
            sfe_pkg::POS_CR:
            begin
                char_next = sfe_pkg::CH_CR;
                end_next  = 1'b1;
            end
            default:                char_next = sfe_pkg::CH_CR;
        endcase

        // The start character restarts the checksum; the carriage return
        // clears it, and the checksum characters themselves are not counted.
        sum_next = sum_reg;
        priority if (cur_pos == sfe_pkg::POS_HDR_START)
        begin
            sum_next = {4'h0, sfe_pkg::CH_START};
        end
        else if (cur_pos == sfe_pkg::POS_CR)
        begin
            sum_next = 12'h000;
        end
        else if (cur_pos != sfe_pkg::POS_SUM_HI && cur_pos != sfe_pkg::POS_SUM_LO)
        begin
            sum_next = sum_reg + {4'h0, char_next};
        end

        // Next position, skipping absent sections.
        job_done = 1'b0;
        pos_next = cur_pos + sfe_pkg::pos_t'(1);
        if (cur_pos == sfe_pkg::POS_HDR_CMD)
        begin
            if (head_job.grp)
            begin
                pos_next = sfe_pkg::POS_GRP_0;
            end
            else if (head_job.close)
            begin
                pos_next = sfe_pkg::POS_SUM_HI;
            end
            else
            begin
                job_done = 1'b1;
            end
        end
        else if (cur_pos == sfe_pkg::POS_GRP_3)
        begin
            job_done = !head_job.close;
        end
        else if (cur_pos == sfe_pkg::POS_CR)
        begin
            job_done = 1'b1;
        end

        last_next      = job_done;
        busy_next      = load ? !job_done : busy_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ch.ready);
    end

    // Control state and checksum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= sfe_pkg::POS_HDR_START;
            sum_reg       <= 12'h000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            end_reg  <= end_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== rtl/core/serial_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// serial_frame_encoder_unit
// Serial command frame encoder: header, 6-bit grouped payload, checksum, CR.
// ----------------------------------------------------------------------------
// The unit takes one payload request per cycle while its two-entry job queue
// has room, and emits one frame character per cycle while the output channel
// is ready and a job is queued. A request causes no character when empty,
// three for a header, four for a group of three payload bytes, completed or
// zero-padded, and three for the frame close, so at most ten. A request that
// causes no character is absorbed without a job. The output character rate
// of one per cycle, set by the back-end character sequencer, bounds the
// sustained rate: four characters per three payload bytes within a frame. A
// request's job is queued before its characters enter the output register.
module serial_frame_encoder_unit (
    input  logic      clk,
    input  logic      rst_n,
    sfe_in_if.sink    in_ch,
    sfe_out_if.source out_ch
);

    logic          push;
    sfe_pkg::job_t push_job;
    logic          queue_full;
    logic          pop;
    logic          head_valid;
    sfe_pkg::job_t head_job;

    // Front part: grouping and classification.
    sfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    // Job queue between the two parts.
    sfe_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back part: character sequencing and checksum.
    sfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
